@@ design/sha_pkg.sv @@
`default_nettype none
package sha_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FOLD,
    ST_PAD,
    ST_OUT
  } state_t;

  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    ror = (x >> n) | (x << (32 - n));
  endfunction

endpackage
`default_nettype wire

@@ design/sha256_byte_stream_hasher.sv @@
// SHA-256 hasher fed one message byte per request.
// Input channel: in_data_byte/in_has_byte/in_end_of_message with
// in_valid/in_ready. A request with in_has_byte=0 and no end is dropped.
// Result channel: out_digest_word/out_word_index/out_last_word with
// out_valid/out_ready; eight requests per message, word 0 first.
// Flow: a byte that neither fills the block nor ends the message leaves
// in_ready high. A byte that fills the block starts the compression: 64
// rounds on the shared round unit, then the fold, during which in_ready
// is low. At end of message the pad byte, the length and one or two
// compressions run, then the eight digest words go out one per cycle as
// the receiver takes them.
// The message schedule is a 16-word sliding window; one W word is
// produced per round alongside the round.
// A stalled receiver holds the current digest word; nothing else moves
// until all eight are taken. After the last word the chaining value is
// back at the initial hash and the next message can start.
// Reset (rst_n low, synchronous) loads the initial hash and clears the
// byte count, bit count and block buffer.
`default_nettype none
module sha256_byte_stream_hasher (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [7:0]  in_data_byte,
  input  wire         in_has_byte,
  input  wire         in_end_of_message,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);
  import sha_pkg::*;

  state_t state_r, state_nxt;
  logic [31:0] h_r [8];
  logic [31:0] v_r [8];
  logic [31:0] w_r [16];
  logic [5:0]  pos_r;
  logic [63:0] bits_r;
  logic [5:0]  rnd_r;
  logic        fin_r;       // end of message pending
  logic        padded_r;    // pad byte placed
  logic        len_done_r;  // length words placed
  logic [2:0]  oidx_r;

  // control decodes
  logic acc, do_round, do_fold, do_pad, out_fire;
  logic [7:0] put_b;
  logic put_en, len_en;

  assign acc = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          if (in_has_byte && pos_r == 6'd63) state_nxt = ST_ROUND;
          else if (in_end_of_message) state_nxt = ST_PAD;
        end
      end
      ST_ROUND: if (rnd_r == 6'd63) state_nxt = ST_FOLD;
      ST_FOLD: begin
        if (!fin_r) state_nxt = ST_IDLE;
        else if (len_done_r) state_nxt = ST_OUT;
        else state_nxt = ST_PAD;
      end
      ST_PAD: begin
        // pad byte first; the length follows in the same block when it fits
        if (padded_r || pos_r >= LEN_POS) state_nxt = ST_ROUND;
      end
      ST_OUT: if (out_fire && oidx_r == 3'd7) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs / controls
  always_comb begin
    in_ready = 1'b0;
    do_round = 1'b0;
    do_fold  = 1'b0;
    do_pad   = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE:  in_ready = 1'b1;
      ST_ROUND: do_round = 1'b1;
      ST_FOLD:  do_fold = 1'b1;
      ST_PAD:   do_pad = 1'b1;
      ST_OUT:   out_valid = 1'b1;
      default: ;
    endcase
  end

  // byte write into window: input byte, or pad byte
  assign put_en = (acc && in_has_byte) || (do_pad && !padded_r);
  assign put_b  = do_pad ? PAD_BYTE : in_data_byte;
  // length goes in after the pad byte: in the cycle after it when it fits, else after that block's compression
  assign len_en = do_pad && padded_r;

  // round unit
  logic [31:0] s0, s1, wnew, big1, ch, t1, big0, maj;
  always_comb begin
    s0   = ror(w_r[1], 7) ^ ror(w_r[1], 18) ^ (w_r[1] >> 3);
    s1   = ror(w_r[14], 17) ^ ror(w_r[14], 19) ^ (w_r[14] >> 10);
    wnew = w_r[0] + s0 + w_r[9] + s1;
    big1 = ror(v_r[4], 6) ^ ror(v_r[4], 11) ^ ror(v_r[4], 25);
    ch   = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    t1   = v_r[7] + big1 + ch + ROUND_K[rnd_r] + w_r[0];
    big0 = ror(v_r[0], 2) ^ ror(v_r[0], 13) ^ ror(v_r[0], 22);
    maj  = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pos_r <= '0;
      bits_r <= '0;
      rnd_r <= '0;
      fin_r <= 1'b0;
      padded_r <= 1'b0;
      len_done_r <= 1'b0;
      oidx_r <= '0;
      for (int i = 0; i < 8; i++) begin
        h_r[i] <= IV[i];
        v_r[i] <= IV[i];
      end
      for (int i = 0; i < 16; i++) w_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      if (acc) begin
        if (in_has_byte) bits_r <= bits_r + 64'd8;
        if (in_end_of_message) fin_r <= 1'b1;
      end
      if (put_en) begin
        w_r[pos_r[5:2]][{~pos_r[1:0], 3'b000} +: 8] <= put_b;
        pos_r <= pos_r + 6'd1;
        if (do_pad) padded_r <= 1'b1;
      end
      if (len_en) begin
        w_r[14] <= bits_r[63:32];
        w_r[15] <= bits_r[31:0];
        len_done_r <= 1'b1;
      end
      if (do_round) begin
        for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
        w_r[15] <= wnew;
        v_r[7] <= v_r[6];
        v_r[6] <= v_r[5];
        v_r[5] <= v_r[4];
        v_r[4] <= v_r[3] + t1;
        v_r[3] <= v_r[2];
        v_r[2] <= v_r[1];
        v_r[1] <= v_r[0];
        v_r[0] <= t1 + big0 + maj;
        rnd_r <= rnd_r + 6'd1;
      end
      if (do_fold) begin
        for (int i = 0; i < 8; i++) begin
          h_r[i] <= h_r[i] + v_r[i];
          v_r[i] <= h_r[i] + v_r[i];
        end
        for (int i = 0; i < 16; i++) w_r[i] <= '0;
        pos_r <= '0;
      end
      if (state_r == ST_OUT && out_fire) begin
        oidx_r <= oidx_r + 3'd1;
        if (oidx_r == 3'd7) begin
          for (int i = 0; i < 8; i++) begin
            h_r[i] <= IV[i];
            v_r[i] <= IV[i];
          end
          bits_r <= '0;
          fin_r <= 1'b0;
          padded_r <= 1'b0;
          len_done_r <= 1'b0;
        end
      end
    end
  end

  assign out_digest_word = h_r[oidx_r];
  assign out_word_index  = oidx_r;
  assign out_last_word   = (oidx_r == 3'd7);

  property p_ready_idle;
    @(posedge clk) disable iff (!rst_n) in_ready |-> !out_valid;
  endproperty
  a_ready_idle: assert property (p_ready_idle) else $error("ready while emitting");

  a_round_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FOLD) |-> (rnd_r == 6'd0))
    else $error("fold before 64 rounds");

  a_out_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT) |-> (fin_r && len_done_r))
    else $error("digest without length block");

  a_idx_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(oidx_r))
    else $error("word index moved under stall");

endmodule
`default_nettype wire
